@@ rtl/core/gjs_pkg.sv @@
package gjs_pkg;

   localparam int JOB_W   = 5;
   localparam int MACH_W  = 5;
   localparam int PTIME_W = 16;
   localparam int INDEX_W = 3;

   // control for the commit side of the schedule tables
   typedef struct packed {
      logic commit;
      logic clear_all;
   } gjs_ctl_type;

endpackage

@@ rtl/core/greedy_job_shop_schedule_decoder_unit.sv @@
// Greedy job-shop decoder: each req beat is one candidate (machine, processing
// time) of a job step; the step's candidates arrive in a row and, of the first
// CANDIDATES of them, the one with the earliest finish wins, the earlier one on
// a tie. The beat marked last_candidate commits the winner to the machine and
// job tables and yields one rsp beat; other beats yield none. One beat is taken
// per clock while req_ready is high. A beat is held in the input register, is
// evaluated in a single pass (job table read, two busy-time reads, max, add,
// compare against the running best), and a closing beat's result lands in the
// output register, which drives rsp_valid. A closing beat waits in the input
// register while an earlier result is still unaccepted, which holds off req.
// A closing beat with last_gene closes the schedule: the result carries the
// makespan and all tables clear in the same cycle.
module greedy_job_shop_schedule_decoder_unit
   import gjs_pkg::*;
#(
   parameter int JOBS       = 32,
   parameter int MACHINES   = 32,
   parameter int CANDIDATES = 8,
   parameter int TIME_BITS  = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [JOB_W-1:0]     req_job_id,
   input  logic                 req_later_step,
   input  logic [MACH_W-1:0]    req_machine_id,
   input  logic [PTIME_W-1:0]   req_proc_time,
   input  logic                 req_last_candidate,
   input  logic                 req_last_gene,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [INDEX_W-1:0]   rsp_chosen_index,
   output logic [MACH_W-1:0]    rsp_chosen_machine,
   output logic [TIME_BITS-1:0] rsp_finish_time,
   output logic [TIME_BITS-1:0] rsp_makespan,
   output logic                 rsp_schedule_done
);

   localparam int IDX_W = (CANDIDATES > 1) ? $clog2(CANDIDATES) : 1;
   localparam int CNT_W = $clog2(CANDIDATES + 1);

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [JOB_W-1:0]     in_job_ff;
   logic                 in_later_ff;
   logic [MACH_W-1:0]    in_machine_ff;
   logic [PTIME_W-1:0]   in_ptime_ff;
   logic                 in_last_cand_ff;
   logic                 in_last_gene_ff;

   // step and schedule state
   logic [TIME_BITS-1:0] best_finish_ff, best_finish_in;
   logic [MACH_W-1:0]    best_machine_ff, best_machine_in;
   logic [IDX_W-1:0]     best_pos_ff, best_pos_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [TIME_BITS-1:0] makespan_ff, makespan_in;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [MACH_W-1:0]    rsp_machine_ff;
   logic [TIME_BITS-1:0] rsp_finish_ff;
   logic [TIME_BITS-1:0] rsp_makespan_ff;
   logic                 rsp_done_ff;

   logic                 advance;
   logic                 req_take;
   gjs_ctl_type          ctl;
   logic [TIME_BITS-1:0] busy_machine;
   logic [TIME_BITS-1:0] busy_prev;
   logic [TIME_BITS-1:0] new_finish;
   logic [MACH_W-1:0]    new_machine;
   logic [IDX_W-1:0]     new_index;
   logic [CNT_W-1:0]     new_count;
   logic [TIME_BITS-1:0] makespan_new;

   // only a closing beat needs room in the output register
   assign advance   = in_valid_ff && (!in_last_cand_ff || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign ctl.commit    = advance && in_last_cand_ff;
   assign ctl.clear_all = advance && in_last_cand_ff && in_last_gene_ff;

   gjs_regfile #(
      .JOBS      (JOBS),
      .MACHINES  (MACHINES),
      .TIME_BITS (TIME_BITS)
   ) u_regfile (
      .clock        (clock),
      .reset        (reset),
      .rd_job       (in_job_ff),
      .rd_machine   (in_machine_ff),
      .busy_machine (busy_machine),
      .busy_prev    (busy_prev),
      .ctl          (ctl),
      .wr_job       (in_job_ff),
      .wr_machine   (new_machine),
      .wr_finish    (new_finish)
   );

   gjs_eval #(
      .CANDIDATES (CANDIDATES),
      .TIME_BITS  (TIME_BITS),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W)
   ) u_eval (
      .later_step   (in_later_ff),
      .machine_id   (in_machine_ff),
      .proc_time    (in_ptime_ff),
      .busy_machine (busy_machine),
      .busy_prev    (busy_prev),
      .count        (count_ff),
      .best_finish  (best_finish_ff),
      .best_machine (best_machine_ff),
      .best_pos     (best_pos_ff),
      .new_finish   (new_finish),
      .new_machine  (new_machine),
      .new_index    (new_index),
      .new_count    (new_count)
   );

   assign makespan_new = (new_finish > makespan_ff) ? new_finish : makespan_ff;

   always_comb begin
      in_valid_in     = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      best_finish_in  = best_finish_ff;
      best_machine_in = best_machine_ff;
      best_pos_in     = best_pos_ff;
      count_in        = count_ff;
      makespan_in     = makespan_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      if (advance) begin
         if (in_last_cand_ff) begin
            best_finish_in  = {TIME_BITS{1'b1}};
            best_machine_in = '0;
            best_pos_in     = '0;
            count_in        = '0;
            makespan_in     = in_last_gene_ff ? '0 : makespan_new;
            rsp_valid_in    = 1'b1;
         end else begin
            best_finish_in  = new_finish;
            best_machine_in = new_machine;
            best_pos_in     = new_index;
            count_in        = new_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         best_finish_ff  <= {TIME_BITS{1'b1}};
         best_machine_ff <= '0;
         best_pos_ff     <= '0;
         count_ff        <= '0;
         makespan_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         in_valid_ff     <= in_valid_in;
         best_finish_ff  <= best_finish_in;
         best_machine_ff <= best_machine_in;
         best_pos_ff     <= best_pos_in;
         count_ff        <= count_in;
         makespan_ff     <= makespan_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_job_ff       <= req_job_id;
         in_later_ff     <= req_later_step;
         in_machine_ff   <= req_machine_id;
         in_ptime_ff     <= req_proc_time;
         in_last_cand_ff <= req_last_candidate;
         in_last_gene_ff <= req_last_gene;
      end
      if (ctl.commit) begin
         rsp_index_ff    <= INDEX_W'(new_index);
         rsp_machine_ff  <= new_machine;
         rsp_finish_ff   <= new_finish;
         rsp_makespan_ff <= makespan_new;
         rsp_done_ff     <= in_last_gene_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_index   = rsp_index_ff;
   assign rsp_chosen_machine = rsp_machine_ff;
   assign rsp_finish_time    = rsp_finish_ff;
   assign rsp_makespan       = rsp_makespan_ff;
   assign rsp_schedule_done  = rsp_done_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CANDIDATES))
      else $error("candidate count beyond limit");

   a_makespan_covers: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_makespan >= rsp_finish_time))
      else $error("makespan below finish time");

   a_schedule_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clear_all |=> (makespan_ff == '0 && count_ff == '0))
      else $error("schedule state not cleared");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && in_last_cand_ff && rsp_valid_ff && !rsp_ready))
      else $error("input stalled without a blocked result");
`endif

endmodule

@@ rtl/core/gjs_regfile.sv @@
module gjs_regfile
   import gjs_pkg::*;
#(
   parameter int JOBS      = 32,
   parameter int MACHINES  = 32,
   parameter int TIME_BITS = 24
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [JOB_W-1:0]     rd_job,
   input  logic [MACH_W-1:0]    rd_machine,
   output logic [TIME_BITS-1:0] busy_machine,
   output logic [TIME_BITS-1:0] busy_prev,
   input  gjs_ctl_type          ctl,
   input  logic [JOB_W-1:0]     wr_job,
   input  logic [MACH_W-1:0]    wr_machine,
   input  logic [TIME_BITS-1:0] wr_finish
);

   localparam int MA_W  = (MACHINES > 1) ? $clog2(MACHINES) : 1;
   localparam int JA_W  = (JOBS > 1) ? $clog2(JOBS) : 1;
   localparam int MX_W  = ((MA_W > MACH_W) ? MA_W : MACH_W) + 1;
   localparam int JX_W  = ((JA_W > JOB_W) ? JA_W : JOB_W) + 1;

   logic [TIME_BITS-1:0] busy_ff [MACHINES];
   logic [MACH_W-1:0]    prev_ff [JOBS];

   logic [MX_W-1:0]   rd_mach_x;
   logic [MX_W-1:0]   prev_x;
   logic [MX_W-1:0]   wr_mach_x;
   logic [JX_W-1:0]   rd_job_x;
   logic [JX_W-1:0]   wr_job_x;
   logic [MACH_W-1:0] prev_machine;

   assign rd_mach_x = MX_W'(rd_machine);
   assign wr_mach_x = MX_W'(wr_machine);
   assign rd_job_x  = JX_W'(rd_job);
   assign wr_job_x  = JX_W'(wr_job);

   // out of range jobs and machines read as zero
   assign prev_machine = (rd_job_x < JX_W'(JOBS)) ? prev_ff[rd_job_x[JA_W-1:0]] : '0;
   assign prev_x       = MX_W'(prev_machine);

   assign busy_machine = (rd_mach_x < MX_W'(MACHINES)) ?
                         busy_ff[rd_mach_x[MA_W-1:0]] : '0;
   assign busy_prev    = (prev_x < MX_W'(MACHINES)) ? busy_ff[prev_x[MA_W-1:0]] : '0;

   always_ff @(posedge clock) begin
      if (reset || ctl.clear_all) begin
         for (int i = 0; i < MACHINES; i++) begin
            busy_ff[i] <= '0;
         end
         for (int j = 0; j < JOBS; j++) begin
            prev_ff[j] <= '0;
         end
      end else if (ctl.commit) begin
         if (wr_mach_x < MX_W'(MACHINES)) begin
            busy_ff[wr_mach_x[MA_W-1:0]] <= wr_finish;
         end
         if (wr_job_x < JX_W'(JOBS)) begin
            prev_ff[wr_job_x[JA_W-1:0]] <= wr_machine;
         end
      end
   end

endmodule

@@ rtl/core/gjs_eval.sv @@
module gjs_eval
   import gjs_pkg::*;
#(
   parameter int CANDIDATES = 8,
   parameter int TIME_BITS  = 24,
   parameter int IDX_W      = 3,
   parameter int CNT_W      = 4
) (
   input  logic                 later_step,
   input  logic [MACH_W-1:0]    machine_id,
   input  logic [PTIME_W-1:0]   proc_time,
   input  logic [TIME_BITS-1:0] busy_machine,
   input  logic [TIME_BITS-1:0] busy_prev,
   input  logic [CNT_W-1:0]     count,
   input  logic [TIME_BITS-1:0] best_finish,
   input  logic [MACH_W-1:0]    best_machine,
   input  logic [IDX_W-1:0]     best_pos,
   output logic [TIME_BITS-1:0] new_finish,
   output logic [MACH_W-1:0]    new_machine,
   output logic [IDX_W-1:0]     new_index,
   output logic [CNT_W-1:0]     new_count
);

   localparam int SUM_W = ((TIME_BITS > PTIME_W) ? TIME_BITS : PTIME_W) + 1;

   logic                 room;
   logic                 take;
   logic [TIME_BITS-1:0] start;
   logic [SUM_W-1:0]     sum;
   logic [TIME_BITS-1:0] finish;

   assign room  = count < CNT_W'(CANDIDATES);
   assign start = (later_step && (busy_prev > busy_machine)) ? busy_prev : busy_machine;
   assign sum   = SUM_W'(start) + SUM_W'(proc_time);
   // saturate at the top of the time range
   assign finish = (sum > SUM_W'({TIME_BITS{1'b1}})) ? {TIME_BITS{1'b1}} :
                   sum[TIME_BITS-1:0];
   // first candidate always wins, later ones only on a strictly earlier finish
   assign take  = room && ((count == '0) || (finish < best_finish));

   assign new_finish  = take ? finish : best_finish;
   assign new_machine = take ? machine_id : best_machine;
   assign new_index   = take ? IDX_W'(count) : best_pos;
   assign new_count   = room ? count + CNT_W'(1) : count;

endmodule

@@ dv/testbench.sv @@
module testbench;
   import gjs_pkg::*;

   localparam int N_JOBS      = 32;
   localparam int N_MACH      = 32;
   localparam int N_CAND      = 8;
   localparam int TB          = 24;
   localparam int ITEM_TARGET = 1650;
   localparam logic [TB-1:0] TIME_SAT = '1;

   typedef struct {
      logic [JOB_W-1:0]   job;
      logic               later;
      logic [MACH_W-1:0]  mach;
      logic [PTIME_W-1:0] ptime;
      logic               last_cand;
      logic               last_gene;
   } candidate_type;

   typedef struct {
      logic [INDEX_W-1:0] index;
      logic [MACH_W-1:0]  mach;
      logic [TB-1:0]      finish;
      logic [TB-1:0]      span;
      logic               done;
   } decision_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [JOB_W-1:0]   req_job_id = '0;
   logic               req_later_step = 1'b0;
   logic [MACH_W-1:0]  req_machine_id = '0;
   logic [PTIME_W-1:0] req_proc_time = '0;
   logic               req_last_candidate = 1'b0;
   logic               req_last_gene = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [INDEX_W-1:0] rsp_chosen_index;
   logic [MACH_W-1:0]  rsp_chosen_machine;
   logic [TB-1:0]      rsp_finish_time;
   logic [TB-1:0]      rsp_makespan;
   logic               rsp_schedule_done;

   greedy_job_shop_schedule_decoder_unit #(
      .JOBS       (N_JOBS),
      .MACHINES   (N_MACH),
      .CANDIDATES (N_CAND),
      .TIME_BITS  (TB)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_job_id         (req_job_id),
      .req_later_step     (req_later_step),
      .req_machine_id     (req_machine_id),
      .req_proc_time      (req_proc_time),
      .req_last_candidate (req_last_candidate),
      .req_last_gene      (req_last_gene),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_chosen_index   (rsp_chosen_index),
      .rsp_chosen_machine (rsp_chosen_machine),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_makespan       (rsp_makespan),
      .rsp_schedule_done  (rsp_schedule_done)
   );

   always #5 clock = ~clock;

   // shadow schedule tables and the step in progress
   logic [TB-1:0]      busy_until [N_MACH];
   logic [MACH_W-1:0]  job_last_mach [N_JOBS];
   logic [TB-1:0]      sched_span;
   logic [TB-1:0]      step_best_end;
   logic [MACH_W-1:0]  step_best_mach;
   logic [INDEX_W-1:0] step_best_pos;
   int                 step_seen;

   decision_type pending_decisions [$];
   int        fails = 0;
   int        items_sent = 0;
   bit        tx_gaps_on = 1'b1;
   bit        rx_stalls_on = 1'b1;
   int        stall_left = 0;
   int        hold_left = 0;

   function automatic void clear_step();
      step_best_end  = TIME_SAT;
      step_best_mach = '0;
      step_best_pos  = '0;
      step_seen      = 0;
   endfunction

   function automatic void clear_schedule();
      foreach (busy_until[m]) busy_until[m] = '0;
      foreach (job_last_mach[j]) job_last_mach[j] = '0;
      sched_span = '0;
   endfunction

   function automatic void schedule_candidate(candidate_type c);
      logic [TB-1:0]     start;
      logic [TB-1:0]     prev_busy;
      logic [TB-1:0]     fin;
      logic [TB:0]       sum;
      logic [MACH_W-1:0] prev;
      decision_type      d;
      if (step_seen < N_CAND) begin
         start = (int'(c.mach) < N_MACH) ? busy_until[c.mach] : '0;
         if (c.later) begin
            prev      = (int'(c.job) < N_JOBS) ? job_last_mach[c.job] : '0;
            prev_busy = (int'(prev) < N_MACH) ? busy_until[prev] : '0;
            if (prev_busy > start) start = prev_busy;
         end
         sum = {1'b0, start} + c.ptime;
         fin = sum[TB] ? TIME_SAT : sum[TB-1:0];
         // first candidate always taken, later ones only when strictly earlier
         if (step_seen == 0 || fin < step_best_end) begin
            step_best_end  = fin;
            step_best_mach = c.mach;
            step_best_pos  = step_seen[INDEX_W-1:0];
         end
         step_seen++;
      end
      if (!c.last_cand) return;
      if (int'(step_best_mach) < N_MACH) busy_until[step_best_mach] = step_best_end;
      if (int'(c.job) < N_JOBS) job_last_mach[c.job] = step_best_mach;
      if (step_best_end > sched_span) sched_span = step_best_end;
      d.index  = step_best_pos;
      d.mach   = step_best_mach;
      d.finish = step_best_end;
      d.span   = sched_span;
      d.done   = c.last_gene;
      pending_decisions.push_back(d);
      clear_step();
      if (c.last_gene) clear_schedule();
   endfunction

   function automatic candidate_type mk_cand(int job, int later, int mach, int ptime,
                                             int last_cand, int last_gene);
      candidate_type c;
      c.job       = job[JOB_W-1:0];
      c.later     = later[0];
      c.mach      = mach[MACH_W-1:0];
      c.ptime     = ptime[PTIME_W-1:0];
      c.last_cand = last_cand[0];
      c.last_gene = last_gene[0];
      return c;
   endfunction

   function automatic logic [PTIME_W-1:0] rand_ptime();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return PTIME_W'($urandom_range(0, 65535));
         default: return PTIME_W'($urandom_range(0, 300));
      endcase
   endfunction

   task automatic send_candidate(input candidate_type c);
      int gap;
      gap = tx_gaps_on ? $urandom_range(0, 11) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_job_id         <= c.job;
      req_later_step     <= c.later;
      req_machine_id     <= c.mach;
      req_proc_time      <= c.ptime;
      req_last_candidate <= c.last_cand;
      req_last_gene      <= c.last_gene;
      do @(posedge clock); while (req_ready !== 1'b1);
      schedule_candidate(c);
      items_sent++;
   endtask

   // receiver: long hold-off first, then the per-beat stall
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : check_rsp
      decision_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         stall_left = rx_stalls_on ? $urandom_range(0, 11) : 0;
         if (pending_decisions.size() == 0) begin
            $display("%0t: unexpected beat index=%0d machine=%0d finish=%0d span=%0d done=%0d",
                     $time, rsp_chosen_index, rsp_chosen_machine, rsp_finish_time,
                     rsp_makespan, rsp_schedule_done);
            fails++;
         end else begin
            want = pending_decisions.pop_front();
            if (rsp_chosen_index !== want.index) begin
               $display("%0t: chosen_index expected %0d actual %0d",
                        $time, want.index, rsp_chosen_index);
               fails++;
            end
            if (rsp_chosen_machine !== want.mach) begin
               $display("%0t: chosen_machine expected %0d actual %0d",
                        $time, want.mach, rsp_chosen_machine);
               fails++;
            end
            if (rsp_finish_time !== want.finish) begin
               $display("%0t: finish_time expected %0d actual %0d",
                        $time, want.finish, rsp_finish_time);
               fails++;
            end
            if (rsp_makespan !== want.span) begin
               $display("%0t: makespan expected %0d actual %0d",
                        $time, want.span, rsp_makespan);
               fails++;
            end
            if (rsp_schedule_done !== want.done) begin
               $display("%0t: schedule_done expected %0d actual %0d",
                        $time, want.done, rsp_schedule_done);
               fails++;
            end
         end
      end
   end

   task automatic test_directed_cases();
      // single candidate at the low extremes, then the high extremes
      send_candidate(mk_cand(0, 0, 0, 0, 1, 0));
      send_candidate(mk_cand(31, 1, 31, 65535, 1, 0));
      // tie between the second and third candidate: the earlier one wins
      send_candidate(mk_cand(1, 0, 31, 10, 0, 0));
      send_candidate(mk_cand(1, 0, 2, 100, 0, 0));
      send_candidate(mk_cand(1, 0, 3, 100, 1, 0));
      // later step waits for the machine of the job's previous step
      send_candidate(mk_cand(1, 1, 4, 5, 1, 0));
      // ten candidates: the last two are ignored even though they are faster
      for (int i = 0; i < 10; i++)
         send_candidate(mk_cand(2, 0, 10 + i, (i < 8) ? 20 + (7 - i) : 0, i == 9, 0));
      // schedule end flag on a non-closing beat does nothing
      send_candidate(mk_cand(3, 0, 5, 7, 0, 1));
      send_candidate(mk_cand(3, 0, 6, 3, 1, 0));
      // commit uses the job of the closing beat
      send_candidate(mk_cand(9, 0, 7, 4, 0, 0));
      send_candidate(mk_cand(10, 0, 8, 9, 1, 0));
      send_candidate(mk_cand(10, 1, 1, 1, 1, 0));
      send_candidate(mk_cand(4, 1, 31, 1, 1, 1));
      // everything cleared after the schedule end
      send_candidate(mk_cand(31, 1, 31, 0, 1, 0));
      send_candidate(mk_cand(10, 1, 0, 2, 1, 1));
   endtask

   task automatic test_saturation();
      tx_gaps_on = 1'b0;
      // 257 full-length steps push machine 9 past the time range
      for (int i = 0; i < 257; i++)
         send_candidate(mk_cand(7, 1, 9, 65535, 1, 0));
      tx_gaps_on = 1'b1;
      for (int i = 0; i < 3; i++)
         send_candidate(mk_cand(7, 1, 9, 65535, i == 2, 0));
      send_candidate(mk_cand(7, 1, 0, 5, 0, 0));
      send_candidate(mk_cand(7, 1, 1, 0, 1, 0));
      send_candidate(mk_cand(8, 0, 2, 1, 1, 1));
   endtask

   task automatic test_backpressure();
      tx_gaps_on = 1'b0;
      hold_left  = 300;
      for (int i = 0; i < 60; i++)
         send_candidate(mk_cand($urandom_range(0, 31), $urandom_range(0, 1),
                                $urandom_range(0, 31), rand_ptime(), 1, i == 59));
      tx_gaps_on = 1'b1;
   endtask

   task automatic run_random_schedule();
      bit                seen_job [N_JOBS];
      int                n_steps;
      int                n_cand;
      int                mach_base;
      int                job_base;
      logic [JOB_W-1:0]  job;
      logic              later;
      candidate_type     c;
      n_steps   = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      mach_base = $urandom_range(0, N_MACH - 1);
      job_base  = $urandom_range(0, N_JOBS - 1);
      foreach (seen_job[j]) seen_job[j] = 1'b0;
      for (int s = 0; s < n_steps; s++) begin
         job   = JOB_W'((job_base + $urandom_range(0, 3)) % N_JOBS);
         later = seen_job[job];
         if ($urandom_range(0, 9) == 0) later = ~later;
         seen_job[job] = 1'b1;
         n_cand = ($urandom_range(0, 11) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         for (int k = 0; k < n_cand; k++) begin
            c.job       = job;
            c.later     = later;
            c.mach      = ($urandom_range(0, 4) == 0) ? MACH_W'($urandom_range(0, 31))
                                                      : MACH_W'((mach_base + $urandom_range(0, 3)) % N_MACH);
            c.ptime     = rand_ptime();
            c.last_cand = (k == n_cand - 1);
            c.last_gene = c.last_cand ? (s == n_steps - 1 && $urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 19) == 0);
            // noise: each beat of the step may carry a stray job
            if ($urandom_range(0, 15) == 0) c.job = JOB_W'($urandom_range(0, 31));
            send_candidate(c);
         end
      end
   endtask

   task automatic test_random_schedules();
      int n_sched;
      n_sched = 0;
      while (items_sent < ITEM_TARGET) begin
         case (n_sched % 5)
            2:       begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b1; end
            3:       begin tx_gaps_on = 1'b0; rx_stalls_on = 1'b0; end
            4:       begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b0; end
            default: begin tx_gaps_on = 1'b1; rx_stalls_on = 1'b1; end
         endcase
         run_random_schedule();
         n_sched++;
      end
      tx_gaps_on   = 1'b1;
      rx_stalls_on = 1'b1;
   endtask

   task automatic drain_results();
      int guard;
      guard = 0;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_decisions.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
      if (pending_decisions.size() != 0) begin
         $display("%0t: %0d expected beats never arrived", $time, pending_decisions.size());
         fails++;
      end
   endtask

   initial begin
      clear_schedule();
      clear_step();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_saturation();
      test_backpressure();
      test_random_schedules();
      drain_results();
      if (fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #3000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/gjs_pkg.sv
rtl/core/gjs_regfile.sv
rtl/core/gjs_eval.sv
rtl/core/greedy_job_shop_schedule_decoder_unit.sv
dv/testbench.sv
